/* hw/rtl/sqn_pkg.sv */
package sqn_pkg;

    // Output length limit and the width of the emitted-byte counter.
    localparam int MAX_LEN = 4095;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Reported length field.
    localparam int LEN_W   = 12;
    localparam int LEN_CAP = 4095;

    // Result queue.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             end_mark;
        logic [LEN_W-1:0] out_length;
    } sqn_res_t;

    // Up to two results produced by one accepted word.
    typedef struct packed {
        logic [1:0] num;
        sqn_res_t   res0;
        sqn_res_t   res1;
    } sqn_push_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        if (wide > 32'(LEN_CAP)) begin
            sat_len = LEN_W'(LEN_CAP);
        end else begin
            sat_len = wide[LEN_W-1:0];
        end
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

/* hw/rtl/sqn_core.sv */
module sqn_core
    import sqn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output sqn_push_t  push
);

    logic             lit_reg, lit_next;
    logic             comment_reg, comment_next;
    logic             lws_reg, lws_next;
    logic             bs_reg, bs_next;
    logic             dash_reg, dash_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             flush;
    logic             cur_emit;
    logic [7:0]       cur_byte;
    logic             active;
    logic [CNT_W-1:0] cnt_after_dash;
    logic [CNT_W-1:0] cnt_p1;
    logic [CNT_W-1:0] cnt_p2;
    sqn_res_t         dash_res;
    sqn_res_t         cur_res;

    assign active = 32'(cnt_reg) < 32'(MAX_LEN);
    assign cnt_p1 = cnt_reg + CNT_W'(1);
    assign cnt_p2 = cnt_reg + CNT_W'(2);

    always_comb begin
        lit_next       = lit_reg;
        comment_next   = comment_reg;
        lws_next       = lws_reg;
        bs_next        = bs_reg;
        dash_next      = dash_reg;
        flush          = 1'b0;
        cur_emit       = 1'b0;
        cur_byte       = in_byte;
        cnt_after_dash = cnt_reg;

        if (active) begin
            bs_next = (in_byte == CH_BSLASH);
            if (comment_reg) begin
                if (in_byte == CH_LF) begin
                    comment_next = 1'b0;
                end
            end else begin
                if (dash_reg) begin
                    dash_next = 1'b0;
                    if (in_byte == CH_DASH) begin
                        comment_next = 1'b1;
                    end else begin
                        flush    = 1'b1;
                        lws_next = 1'b0;
                    end
                end
                cnt_after_dash = cnt_reg + CNT_W'(flush);
                // A second dash opens a comment and emits nothing.
                if (!(dash_reg && in_byte == CH_DASH) &&
                    32'(cnt_after_dash) < 32'(MAX_LEN)) begin
                    if (in_byte == CH_QUOTE && !bs_reg) begin
                        lit_next = !lit_reg;
                        cur_emit = 1'b1;
                        lws_next = 1'b0;
                    end else if (lit_reg) begin
                        cur_emit = 1'b1;
                        lws_next = 1'b0;
                    end else if (in_byte == CH_DASH) begin
                        if (in_last) begin
                            cur_emit = 1'b1;
                            lws_next = 1'b0;
                        end else begin
                            dash_next = 1'b1;
                        end
                    end else if (is_ws(in_byte)) begin
                        if (!lws_reg) begin
                            cur_emit = 1'b1;
                            cur_byte = CH_SPACE;
                            lws_next = 1'b1;
                        end
                    end else begin
                        cur_emit = 1'b1;
                        lws_next = 1'b0;
                        if (in_byte >= CH_LOW_A && in_byte <= CH_LOW_Z) begin
                            cur_byte = in_byte - CASE_OFS;
                        end
                    end
                end
            end
        end

        cnt_next = cnt_reg + CNT_W'(flush) + CNT_W'(cur_emit);

        dash_res.out_byte   = CH_DASH;
        dash_res.byte_valid = 1'b1;
        dash_res.end_mark   = 1'b0;
        dash_res.out_length = sat_len(cnt_p1);

        cur_res.out_byte    = cur_byte;
        cur_res.byte_valid  = 1'b1;
        cur_res.end_mark    = 1'b0;
        cur_res.out_length  = flush ? sat_len(cnt_p2) : sat_len(cnt_p1);

        push.num  = 2'(flush) + 2'(cur_emit);
        push.res0 = flush ? dash_res : cur_res;
        push.res1 = cur_res;

        if (in_last) begin
            case (push.num)
                2'd0: begin
                    push.num             = 2'd1;
                    push.res0.out_byte   = 8'h00;
                    push.res0.byte_valid = 1'b0;
                    push.res0.end_mark   = 1'b1;
                    push.res0.out_length = sat_len(cnt_reg);
                end
                2'd1: push.res0.end_mark = 1'b1;
                default: push.res1.end_mark = 1'b1;
            endcase
            lit_next     = 1'b0;
            comment_next = 1'b0;
            lws_next     = 1'b1;
            bs_next      = 1'b0;
            dash_next    = 1'b0;
            cnt_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg     <= 1'b0;
            comment_reg <= 1'b0;
            lws_reg     <= 1'b1;
            bs_reg      <= 1'b0;
            dash_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else if (accept) begin
            lit_reg     <= lit_next;
            comment_reg <= comment_next;
            lws_reg     <= lws_next;
            bs_reg      <= bs_next;
            dash_reg    <= dash_next;
            cnt_reg     <= cnt_next;
        end
    end

    // The counter never passes the limit.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(MAX_LEN))
        else $error("emitted count beyond limit");

    // A final word always closes the query and returns the modes to reset.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_last |=> cnt_reg == '0 && !lit_reg && !comment_reg && !dash_reg)
        else $error("state not cleared after final word");

    // A comment and a held dash never coexist.
    a_modes_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(comment_reg && dash_reg))
        else $error("comment and held dash both set");

endmodule

/* hw/rtl/sqn_outq.sv */
module sqn_outq
    import sqn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_en,
    input  sqn_push_t  push,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output sqn_res_t   head
);

    sqn_res_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [1:0]           push_num;
    logic                 pop;

    assign push_num = push_en ? push.num : 2'd0;
    assign m_valid  = (count_reg != '0);
    assign pop      = m_valid && m_ready;
    // Space for two results is kept free before a new word is taken.
    assign room     = 32'(count_reg) <= 32'(Q_DEPTH - 2);
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push_num == 2'd2) begin
            mem[wr_ptr_reg + Q_PTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push_num);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            count_reg  <= count_reg + Q_CNT_W'(push_num) - Q_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(Q_DEPTH))
        else $error("result queue overflow");

    // A word that yields no result is still taken, so only room is required.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> room)
        else $error("push without room");

endmodule

/* hw/rtl/sql_query_text_normalizer.sv */
// A result word enters the result queue when its input word is accepted and is offered on
// the m_ side from the queue head. Throughput: one input word per cycle while s_ready is
// high; a word that yields two results (a flushed dash plus the current byte) fills two
// queue entries. s_ready follows the fill level of the four-entry result queue.
// Reset: synchronous, active low; resets all mode bits and clears the count and the queue.
module sql_query_text_normalizer
    import sqn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_in_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_end_mark,
    output logic [LEN_W-1:0] m_out_length
);

    logic      accept;
    logic      room;
    sqn_push_t push;
    sqn_res_t  head;

    assign s_ready = room;
    assign accept  = s_valid && room;

    sqn_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push)
    );

    sqn_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (accept),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_byte   = head.out_byte;
    assign m_byte_valid = head.byte_valid;
    assign m_end_mark   = head.end_mark;
    assign m_out_length = head.out_length;

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqn_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Mirrors the normalizer's mode bits and keeps the results it should produce, oldest first.
    class norm_scoreboard;
        sqn_res_t    expected_chars[$];
        sqn_res_t    step_chars[$];
        bit          in_literal;
        bit          comment_open;
        bit          last_blank;
        bit          prev_bslash;
        bit          dash_held;
        int unsigned emitted;
        int unsigned errors;

        function new();
            errors = 0;
            clear_query();
        endfunction

        function void clear_query();
            in_literal   = 1'b0;
            comment_open = 1'b0;
            last_blank   = 1'b1;
            prev_bslash  = 1'b0;
            dash_held    = 1'b0;
            emitted      = 0;
        endfunction

        function logic [LEN_W-1:0] length_now();
            return (emitted > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(emitted);
        endfunction

        function void put_char(logic [7:0] c);
            sqn_res_t r;
            emitted++;
            r.out_byte   = c;
            r.byte_valid = 1'b1;
            r.end_mark   = 1'b0;
            r.out_length = length_now();
            step_chars.push_back(r);
        endfunction

        function void note_word(logic [7:0] b, bit last);
            bit       skip;
            sqn_res_t r;
            skip = 1'b0;
            step_chars.delete();
            if (emitted < MAX_LEN) begin
                if (comment_open) begin
                    if (b == CH_LF) comment_open = 1'b0;
                end else begin
                    // A held dash is resolved by whatever byte comes next.
                    if (dash_held) begin
                        dash_held = 1'b0;
                        if (b == CH_DASH) begin
                            comment_open = 1'b1;
                            skip = 1'b1;
                        end else begin
                            put_char(CH_DASH);
                            last_blank = 1'b0;
                        end
                    end
                    if (!skip && emitted < MAX_LEN) begin
                        if (b == CH_QUOTE && !prev_bslash) begin
                            in_literal = !in_literal;
                            put_char(b);
                            last_blank = 1'b0;
                        end else if (in_literal) begin
                            put_char(b);
                            last_blank = 1'b0;
                        end else if (b == CH_DASH) begin
                            if (last) begin
                                put_char(b);
                                last_blank = 1'b0;
                            end else begin
                                dash_held = 1'b1;
                            end
                        end else if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
                            if (!last_blank) begin
                                put_char(CH_SPACE);
                                last_blank = 1'b1;
                            end
                        end else begin
                            put_char((b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_OFS : b);
                            last_blank = 1'b0;
                        end
                    end
                end
                prev_bslash = (b == CH_BSLASH);
            end
            if (last) begin
                if (step_chars.size() > 0) begin
                    step_chars[step_chars.size()-1].end_mark = 1'b1;
                end else begin
                    r.out_byte   = 8'h00;
                    r.byte_valid = 1'b0;
                    r.end_mark   = 1'b1;
                    r.out_length = length_now();
                    step_chars.push_back(r);
                end
                clear_query();
            end
            foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
        endfunction

        function void check_result(sqn_res_t got);
            sqn_res_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected result: out_byte %0h end_mark %0b", got.out_byte, got.end_mark);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.end_mark !== want.end_mark) begin
                $error("end_mark: expected %0b, got %0b", want.end_mark, got.end_mark);
                errors++;
            end
            if (got.out_length !== want.out_length) begin
                $error("out_length: expected %0d, got %0d", want.out_length, got.out_length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_in_byte;
    logic             s_in_last;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_out_byte;
    logic             m_byte_valid;
    logic             m_end_mark;
    logic [LEN_W-1:0] m_out_length;

    norm_scoreboard sb;
    byte_q_t        query_buf;
    bit             steady;
    bit             hold_out_req;
    bit             hold_done;
    int             random_sent;

    sql_query_text_normalizer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_end_mark   (m_end_mark),
        .m_out_length (m_out_length)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_word(input logic [7:0] b, input bit last);
        if (!steady) begin
            while ($urandom_range(0, 99) < 31) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(b, last);
    endtask

    task automatic send_query(input byte_q_t text);
        foreach (text[i]) send_word(text[i], i == text.size() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                    : 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] rand_ws();
        logic [7:0] ws_set[6];
        ws_set = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        return ws_set[$urandom_range(0, 5)];
    endfunction

    // Mostly SQL-shaped tokens; the last cases are plain noise.
    function automatic void append_token();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 8);
                repeat (n) query_buf.push_back($urandom_range(0, 4) == 0 ?
                    8'($urandom_range(8'h30, 8'h39)) : rand_letter());
            end
            3: begin
                n = $urandom_range(1, 3);
                repeat (n) query_buf.push_back(rand_ws());
            end
            4: begin
                query_buf.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            query_buf.push_back(CH_BSLASH);
                            query_buf.push_back(CH_QUOTE);
                        end
                        1: query_buf.push_back(CH_DASH);
                        2: query_buf.push_back(rand_ws());
                        3: query_buf.push_back(8'($urandom_range(1, 255)));
                        default: query_buf.push_back(rand_letter());
                    endcase
                end
                query_buf.push_back(CH_QUOTE);
            end
            5: begin
                query_buf.push_back(CH_DASH);
                query_buf.push_back(CH_DASH);
                n = $urandom_range(0, 6);
                repeat (n) query_buf.push_back(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 3) != 0) query_buf.push_back(CH_LF);
            end
            6: query_buf.push_back(CH_DASH);
            7: query_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
            8: query_buf.push_back(8'($urandom_range(1, 255)));
            default: query_buf.push_back(CH_BSLASH);
        endcase
    endfunction

    initial begin
        #5ms;
        $display("FAIL sql_query_text_normalizer");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        sqn_res_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                repeat (300) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.out_byte   = m_out_byte;
                got.byte_valid = m_byte_valid;
                got.end_mark   = m_end_mark;
                got.out_length = m_out_length;
                sb.check_result(got);
            end
        end
    end

    initial begin
        sb           = new();
        steady       = 1'b0;
        hold_out_req = 1'b0;
        hold_done    = 1'b0;
        random_sent  = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_in_byte    = 8'h01;
        s_in_last    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Leading whitespace, case folding, a dash flushed together with the next byte,
        // and a final newline that yields only the end result.
        send_query('{CH_SPACE, CH_TAB, 8'h61, 8'h7A, CH_DASH, 8'h62, CH_CR, CH_LF});
        // Comment through a newline, an escaped quote inside a literal, dashes in a
        // literal, byte extremes and a dash as the final byte.
        send_query('{8'h78, CH_DASH, CH_DASH, 8'h71, CH_LF, CH_QUOTE, CH_BSLASH, CH_QUOTE,
                     CH_DASH, CH_DASH, 8'h01, CH_QUOTE, 8'hFF, CH_DASH});
        // Comment still open at the end, then a query that emits nothing.
        send_query('{CH_DASH, CH_DASH, 8'h63});
        send_query('{CH_SPACE});

        // Fill all but one slot so that a flushed dash takes the last one; the rest is dropped.
        query_buf.delete();
        repeat (MAX_LEN - 1) query_buf.push_back(rand_letter());
        query_buf.push_back(CH_DASH);
        query_buf.push_back(8'h78);
        query_buf.push_back(8'h79);
        query_buf.push_back(CH_QUOTE);
        query_buf.push_back(CH_SPACE);
        send_query(query_buf);

        while (random_sent < 850) begin
            query_buf.delete();
            repeat ($urandom_range(1, 6)) append_token();
            if (!hold_done && random_sent >= 200) begin
                hold_out_req = 1'b1;
                hold_done    = 1'b1;
            end
            steady = (random_sent >= 400 && random_sent < 550);
            send_query(query_buf);
            random_sent += query_buf.size();
        end

        s_valid <= 1'b0;
        steady = 1'b1;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS sql_query_text_normalizer");
        end else begin
            $display("FAIL sql_query_text_normalizer");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/sqn_pkg.sv
hw/rtl/sqn_core.sv
hw/rtl/sqn_outq.sv
hw/rtl/sql_query_text_normalizer.sv
dv/tb.sv
